@@ rtl/core/dlpi_pkg.sv @@
// Shared types, opcode and register codes, and sequencer states of the line program interpreter.
package dlpi_pkg;

  typedef struct packed {
    logic [7:0]         op;
    logic [7:0]         ext_op;
    logic [63:0]        operand;
    logic signed [31:0] line_delta;
  } in_item_t;

  typedef struct packed {
    logic [63:0] row_pc;
    logic [31:0] row_line;
    logic [31:0] row_column;
    logic [15:0] row_file;
    logic        row_is_stmt;
    logic        row_prologue_end;
    logic        row_basic_block;
    logic        row_epilogue_begin;
    logic        row_end_sequence;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV_LINE,
    ST_DIV_OPS,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       start;
    logic [4:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  localparam logic [7:0] CFG_MIN_INST_LENGTH  = 8'd0;
  localparam logic [7:0] CFG_MAX_OPS_PER_INST = 8'd1;
  localparam logic [7:0] CFG_DEFAULT_STMT     = 8'd2;
  localparam logic [7:0] CFG_LINE_BASE        = 8'd3;
  localparam logic [7:0] CFG_LINE_RANGE       = 8'd4;
  localparam logic [7:0] CFG_FIRST_SPECIAL    = 8'd5;
  localparam logic [7:0] CFG_RELOCATE_BASE    = 8'd6;
  localparam logic [7:0] CFG_LOW_BOUND        = 8'd7;

  localparam logic [7:0] OP_EXTENDED         = 8'd0;
  localparam logic [7:0] OP_COPY             = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC       = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE     = 8'd3;
  localparam logic [7:0] OP_SET_FILE         = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN       = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT      = 8'd6;
  localparam logic [7:0] OP_SET_BASIC_BLOCK  = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC     = 8'd8;
  localparam logic [7:0] OP_FIXED_ADVANCE_PC = 8'd9;
  localparam logic [7:0] OP_SET_PROLOGUE_END = 8'd10;
  localparam logic [7:0] OP_SET_EPILOGUE_BEG = 8'd11;

  localparam logic [7:0] EXT_END_SEQUENCE = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS  = 8'd2;

  localparam logic [7:0] SPECIAL_CONST_ADD = 8'd255;

  localparam logic [4:0] DIV_STEPS_WIDE = 5'd16;
  localparam logic [4:0] DIV_STEPS_ADJ  = 5'd2;
  localparam logic [4:0] DIV_STEPS_SUM  = 5'd3;

endpackage

@@ rtl/core/dlpi_divu.sv @@
// Iterative unsigned divider, 64-bit dividend by 8-bit divisor, four quotient bits per cycle.
module dlpi_divu (
  input  logic               clk,
  input  logic               rst_n,
  input  dlpi_pkg::div_ctl_t ctl,
  input  logic [63:0]        dividend,
  input  logic [7:0]         divisor,
  output dlpi_pkg::div_sts_t sts,
  output logic [63:0]        quot,
  output logic [7:0]         rem
);

  logic [63:0] dq_r, dq_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  d_r;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  always_comb begin
    logic [8:0] t;
    logic [8:0] diff;
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    for (int i = 0; i < 4; i++) begin
      t = {rem_nxt, dq_nxt[63]};
      diff = t - {1'b0, d_r};
      if (t >= {1'b0, d_r}) begin
        rem_nxt = diff[7:0];
        dq_nxt = {dq_nxt[62:0], 1'b1};
      end else begin
        rem_nxt = t[7:0];
        dq_nxt = {dq_nxt[62:0], 1'b0};
      end
    end
    cnt_nxt = cnt_r - 5'd1;
    busy_nxt = busy_r && (cnt_r != 5'd1);
    done_nxt = busy_r && (cnt_r == 5'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= ctl.steps;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dq_r <= dividend;
      rem_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      dq_r <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = dq_r;
  assign rem = rem_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> busy_r && !done_r)
    else $error("divider did not begin after a start");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == 5'd1 && !ctl.start |=> done_r && !busy_r)
    else $error("divider did not finish after its last step");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held for more than one cycle");

endmodule

@@ rtl/core/debug_line_program_interpreter.sv @@
// Top level of the line program interpreter: sequencer, line state, shared adder and divider.
// Simple opcodes return to idle after execute; copy and end-sequence also pass through emit.
// Special opcodes and const-add-pc make two short divider runs, then a shift-add multiply
// whose length is set by min_inst_length; special opcodes then emit a row.
// Advance-pc makes one wide divider run of four bits per step, then the same multiply. A row stalls
// the sequencer only while an earlier row still waits. Synchronous active-low reset.
module debug_line_program_interpreter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlpi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dlpi_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [63:0]         cfg_data
);

  dlpi_pkg::state_t state_r, state_nxt;

  logic [7:0]  min_inst_r, max_ops_r, line_base_r, line_range_r, first_special_r;
  logic        default_stmt_r;
  logic [63:0] relocate_r, low_bound_r;

  logic [63:0] address_r, address_nxt;
  logic [31:0] line_r, line_nxt;
  logic [31:0] column_r, column_nxt;
  logic [31:0] file_r, file_nxt;
  logic [7:0]  op_index_r, op_index_nxt;
  logic        stmt_r, stmt_nxt;
  logic        block_r, block_nxt;
  logic        prologue_r, prologue_nxt;
  logic        epilogue_r, epilogue_nxt;
  logic        record_r, record_nxt;
  logic        out_valid_r, out_valid_nxt;

  dlpi_pkg::in_item_t  item_r;
  dlpi_pkg::out_item_t out_data_r, out_data_nxt;
  logic [63:0] mcand_r, mcand_nxt;
  logic [7:0]  mplier_r, mplier_nxt;
  logic        special_r, special_nxt;
  logic        last_r, last_nxt;

  logic [63:0] add_a, add_b, add_sum;
  logic [7:0]  ops_div, range_div, adj;
  logic        is_special;
  logic [8:0]  ops_sum;

  dlpi_pkg::div_ctl_t div_ctl;
  dlpi_pkg::div_sts_t div_sts;
  logic [63:0] div_dividend, div_quot;
  logic [7:0]  div_divisor, div_rem;

  dlpi_divu u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign ops_div = (max_ops_r == 8'd0) ? 8'd1 : max_ops_r;
  assign range_div = (line_range_r == 8'd0) ? 8'd1 : line_range_r;
  assign is_special = item_r.op >= first_special_r;
  assign adj = is_special ? (item_r.op - first_special_r)
                          : (dlpi_pkg::SPECIAL_CONST_ADD - first_special_r);
  assign ops_sum = {1'b0, op_index_r} + {1'b0, div_quot[7:0]};
  assign add_sum = add_a + add_b;

  assign in_ready = (state_r == dlpi_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    add_a = address_r;
    add_b = relocate_r;
    case (state_r)
      dlpi_pkg::ST_EXEC: begin
        if (!is_special && item_r.op == dlpi_pkg::OP_FIXED_ADVANCE_PC) begin
          add_b = {48'd0, item_r.operand[15:0]};
        end else begin
          add_a = {56'd0, op_index_r};
          add_b = item_r.operand;
        end
      end
      dlpi_pkg::ST_MUL: add_b = mcand_r;
      default: add_b = relocate_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    address_nxt = address_r;
    line_nxt = line_r;
    column_nxt = column_r;
    file_nxt = file_r;
    op_index_nxt = op_index_r;
    stmt_nxt = stmt_r;
    block_nxt = block_r;
    prologue_nxt = prologue_r;
    epilogue_nxt = epilogue_r;
    record_nxt = record_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    special_nxt = special_r;
    last_nxt = last_r;
    div_ctl.start = 1'b0;
    div_ctl.steps = dlpi_pkg::DIV_STEPS_ADJ;
    div_dividend = {adj, 56'd0};
    div_divisor = range_div;

    case (state_r)
      dlpi_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dlpi_pkg::ST_EXEC;
        end
      end
      dlpi_pkg::ST_EXEC: begin
        state_nxt = dlpi_pkg::ST_IDLE;
        special_nxt = is_special;
        last_nxt = 1'b0;
        if (is_special) begin
          div_ctl.start = 1'b1;
          state_nxt = dlpi_pkg::ST_DIV_LINE;
        end else begin
          case (item_r.op)
            dlpi_pkg::OP_EXTENDED: begin
              if (item_r.ext_op == dlpi_pkg::EXT_END_SEQUENCE) begin
                last_nxt = 1'b1;
                state_nxt = dlpi_pkg::ST_EMIT;
              end else if (item_r.ext_op == dlpi_pkg::EXT_SET_ADDRESS) begin
                record_nxt = record_r && (item_r.operand >= low_bound_r);
                address_nxt = item_r.operand;
                op_index_nxt = '0;
              end
            end
            dlpi_pkg::OP_COPY: state_nxt = dlpi_pkg::ST_EMIT;
            dlpi_pkg::OP_ADVANCE_PC: begin
              div_ctl.start = 1'b1;
              div_ctl.steps = dlpi_pkg::DIV_STEPS_WIDE;
              div_dividend = add_sum;
              div_divisor = ops_div;
              state_nxt = dlpi_pkg::ST_DIV_OPS;
            end
            dlpi_pkg::OP_ADVANCE_LINE: line_nxt = line_r + item_r.line_delta;
            dlpi_pkg::OP_SET_FILE: file_nxt = item_r.operand[31:0];
            dlpi_pkg::OP_SET_COLUMN: column_nxt = item_r.operand[31:0];
            dlpi_pkg::OP_NEGATE_STMT: stmt_nxt = !stmt_r;
            dlpi_pkg::OP_SET_BASIC_BLOCK: block_nxt = 1'b1;
            dlpi_pkg::OP_CONST_ADD_PC: begin
              div_ctl.start = 1'b1;
              state_nxt = dlpi_pkg::ST_DIV_LINE;
            end
            dlpi_pkg::OP_FIXED_ADVANCE_PC: begin
              address_nxt = add_sum;
              op_index_nxt = '0;
            end
            dlpi_pkg::OP_SET_PROLOGUE_END: prologue_nxt = 1'b1;
            dlpi_pkg::OP_SET_EPILOGUE_BEG: epilogue_nxt = 1'b1;
            default: state_nxt = dlpi_pkg::ST_IDLE;
          endcase
        end
      end
      dlpi_pkg::ST_DIV_LINE: begin
        if (div_sts.done) begin
          if (special_r) begin
            line_nxt = line_r + {{24{line_base_r[7]}}, line_base_r} + {24'd0, div_rem};
          end
          div_ctl.start = 1'b1;
          div_ctl.steps = dlpi_pkg::DIV_STEPS_SUM;
          div_dividend = {3'd0, ops_sum, 52'd0};
          div_divisor = ops_div;
          state_nxt = dlpi_pkg::ST_DIV_OPS;
        end
      end
      dlpi_pkg::ST_DIV_OPS: begin
        if (div_sts.done) begin
          op_index_nxt = div_rem;
          mcand_nxt = div_quot;
          mplier_nxt = min_inst_r;
          state_nxt = dlpi_pkg::ST_MUL;
        end
      end
      dlpi_pkg::ST_MUL: begin
        if (mplier_r == 8'd0) begin
          state_nxt = special_r ? dlpi_pkg::ST_EMIT : dlpi_pkg::ST_IDLE;
        end else begin
          if (mplier_r[0]) begin
            address_nxt = add_sum;
          end
          mcand_nxt = {mcand_r[62:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[7:1]};
        end
      end
      dlpi_pkg::ST_EMIT: begin
        if (!record_r || !out_valid_r || out_ready) begin
          if (record_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt.row_pc = add_sum;
            out_data_nxt.row_line = line_r;
            out_data_nxt.row_column = column_r;
            out_data_nxt.row_file = file_r[15:0];
            out_data_nxt.row_is_stmt = stmt_r;
            out_data_nxt.row_prologue_end = prologue_r;
            out_data_nxt.row_basic_block = block_r;
            out_data_nxt.row_epilogue_begin = epilogue_r;
            out_data_nxt.row_end_sequence = last_r;
          end
          block_nxt = 1'b0;
          prologue_nxt = 1'b0;
          epilogue_nxt = 1'b0;
          if (last_r) begin
            address_nxt = '0;
            line_nxt = 32'd1;
            column_nxt = '0;
            file_nxt = 32'd1;
            op_index_nxt = '0;
            stmt_nxt = default_stmt_r;
            record_nxt = 1'b1;
          end
          state_nxt = dlpi_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dlpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlpi_pkg::ST_IDLE;
      address_r <= '0;
      line_r <= 32'd1;
      column_r <= '0;
      file_r <= 32'd1;
      op_index_r <= '0;
      stmt_r <= 1'b1;
      block_r <= 1'b0;
      prologue_r <= 1'b0;
      epilogue_r <= 1'b0;
      record_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      address_r <= address_nxt;
      line_r <= line_nxt;
      column_r <= column_nxt;
      file_r <= file_nxt;
      op_index_r <= op_index_nxt;
      stmt_r <= stmt_nxt;
      block_r <= block_nxt;
      prologue_r <= prologue_nxt;
      epilogue_r <= epilogue_nxt;
      record_r <= record_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_inst_r <= 8'd1;
      max_ops_r <= 8'd1;
      default_stmt_r <= 1'b1;
      line_base_r <= 8'hFB;
      line_range_r <= 8'd14;
      first_special_r <= 8'd13;
      relocate_r <= '0;
      low_bound_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlpi_pkg::CFG_MIN_INST_LENGTH: min_inst_r <= cfg_data[7:0];
        dlpi_pkg::CFG_MAX_OPS_PER_INST: max_ops_r <= cfg_data[7:0];
        dlpi_pkg::CFG_DEFAULT_STMT: default_stmt_r <= cfg_data[0];
        dlpi_pkg::CFG_LINE_BASE: line_base_r <= cfg_data[7:0];
        dlpi_pkg::CFG_LINE_RANGE: line_range_r <= cfg_data[7:0];
        dlpi_pkg::CFG_FIRST_SPECIAL: first_special_r <= cfg_data[7:0];
        dlpi_pkg::CFG_RELOCATE_BASE: relocate_r <= cfg_data;
        dlpi_pkg::CFG_LOW_BOUND: low_bound_r <= cfg_data;
        default: min_inst_r <= min_inst_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    out_data_r <= out_data_nxt;
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    special_r <= special_nxt;
    last_r <= last_nxt;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == dlpi_pkg::ST_EXEC)
    else $error("accepted transaction was not executed");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == dlpi_pkg::ST_DIV_LINE || state_r == dlpi_pkg::ST_DIV_OPS)
    else $error("divider finished with no sequencer waiting");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dlpi_pkg::ST_IDLE |-> !div_sts.busy)
    else $error("divider busy while the sequencer is idle");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dlpi_pkg::ST_EMIT && record_r && out_valid_r && !out_ready
    |=> state_r == dlpi_pkg::ST_EMIT && out_valid_r)
    else $error("pending row overwritten");

endmodule

@@ test/debug_line_program_interpreter_checker.sv @@
// Line table state predictor and row checker for the line program interpreter testbench.
module debug_line_program_interpreter_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dlpi_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dlpi_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [63:0]         cfg_data,
  output int                  mismatch_count,
  output int                  rows_waiting
);

  logic [63:0] hdr_min_len;
  logic [7:0]  hdr_max_ops;
  logic        hdr_dflt_stmt;
  logic [7:0]  hdr_line_base;
  logic [7:0]  hdr_line_range;
  logic [7:0]  hdr_first_special;
  logic [63:0] hdr_reloc;
  logic [63:0] hdr_low_bound;

  logic [63:0] pc_reg;
  logic [31:0] line_reg;
  logic [31:0] col_reg;
  logic [31:0] file_reg;
  logic [7:0]  opi_reg;
  logic        stmt_reg;
  logic        blk_reg;
  logic        pro_reg;
  logic        epi_reg;
  logic        rec_reg;

  dlpi_pkg::out_item_t rows_due[$];
  int                  errors;

  task automatic begin_sequence();
    pc_reg   = '0;
    line_reg = 32'd1;
    col_reg  = '0;
    file_reg = 32'd1;
    opi_reg  = '0;
    stmt_reg = hdr_dflt_stmt;
    blk_reg  = 1'b0;
    pro_reg  = 1'b0;
    epi_reg  = 1'b0;
    rec_reg  = 1'b1;
  endtask

  function automatic logic [63:0] divisor(input logic [7:0] v);
    return (v == 8'd0) ? 64'd1 : {56'd0, v};
  endfunction

  task automatic step_ops(input logic [63:0] advance);
    logic [63:0] d;
    logic [63:0] total;
    d = divisor(hdr_max_ops);
    total = {56'd0, opi_reg} + advance;
    pc_reg = pc_reg + (total / d) * hdr_min_len;
    opi_reg = 8'(total % d);
  endtask

  task automatic special_step(input logic [7:0] opcode, input bit move_line);
    logic [63:0] adj;
    logic [63:0] rng;
    adj = {56'd0, opcode - hdr_first_special};
    rng = divisor(hdr_line_range);
    step_ops(adj / rng);
    if (move_line) begin
      line_reg = line_reg + {{24{hdr_line_base[7]}}, hdr_line_base} + 32'(adj % rng);
    end
  endtask

  task automatic record_row(input bit last);
    dlpi_pkg::out_item_t row;
    if (rec_reg) begin
      row.row_pc             = pc_reg + hdr_reloc;
      row.row_line           = line_reg;
      row.row_column         = col_reg;
      row.row_file           = file_reg[15:0];
      row.row_is_stmt        = stmt_reg;
      row.row_prologue_end   = pro_reg;
      row.row_basic_block    = blk_reg;
      row.row_epilogue_begin = epi_reg;
      row.row_end_sequence   = last;
      rows_due = {rows_due, row};
    end
    blk_reg = 1'b0;
    pro_reg = 1'b0;
    epi_reg = 1'b0;
  endtask

  task automatic apply_opcode(input dlpi_pkg::in_item_t item);
    if (item.op >= hdr_first_special) begin
      special_step(item.op, 1'b1);
      record_row(1'b0);
    end else if (item.op == dlpi_pkg::OP_EXTENDED) begin
      if (item.ext_op == dlpi_pkg::EXT_END_SEQUENCE) begin
        record_row(1'b1);
        begin_sequence();
      end else if (item.ext_op == dlpi_pkg::EXT_SET_ADDRESS) begin
        if (rec_reg) begin
          rec_reg = (item.operand >= hdr_low_bound);
        end
        pc_reg  = item.operand;
        opi_reg = '0;
      end
    end else begin
      case (item.op)
        dlpi_pkg::OP_COPY:             record_row(1'b0);
        dlpi_pkg::OP_ADVANCE_PC:       step_ops(item.operand);
        dlpi_pkg::OP_ADVANCE_LINE:     line_reg = line_reg + item.line_delta;
        dlpi_pkg::OP_SET_FILE:         file_reg = item.operand[31:0];
        dlpi_pkg::OP_SET_COLUMN:       col_reg = item.operand[31:0];
        dlpi_pkg::OP_NEGATE_STMT:      stmt_reg = !stmt_reg;
        dlpi_pkg::OP_SET_BASIC_BLOCK:  blk_reg = 1'b1;
        dlpi_pkg::OP_CONST_ADD_PC:     special_step(dlpi_pkg::SPECIAL_CONST_ADD, 1'b0);
        dlpi_pkg::OP_FIXED_ADVANCE_PC: begin
          pc_reg  = pc_reg + {48'd0, item.operand[15:0]};
          opi_reg = '0;
        end
        dlpi_pkg::OP_SET_PROLOGUE_END: pro_reg = 1'b1;
        dlpi_pkg::OP_SET_EPILOGUE_BEG: epi_reg = 1'b1;
        default: ;
      endcase
    end
  endtask

  task automatic apply_header(input logic [7:0] idx, input logic [63:0] value);
    case (idx)
      dlpi_pkg::CFG_MIN_INST_LENGTH:  hdr_min_len = {56'd0, value[7:0]};
      dlpi_pkg::CFG_MAX_OPS_PER_INST: hdr_max_ops = value[7:0];
      dlpi_pkg::CFG_DEFAULT_STMT:     hdr_dflt_stmt = value[0];
      dlpi_pkg::CFG_LINE_BASE:        hdr_line_base = value[7:0];
      dlpi_pkg::CFG_LINE_RANGE:       hdr_line_range = value[7:0];
      dlpi_pkg::CFG_FIRST_SPECIAL:    hdr_first_special = value[7:0];
      dlpi_pkg::CFG_RELOCATE_BASE:    hdr_reloc = value;
      dlpi_pkg::CFG_LOW_BOUND:        hdr_low_bound = value;
      default: ;
    endcase
  endtask

  task automatic check_row(input dlpi_pkg::out_item_t got);
    dlpi_pkg::out_item_t want;
    if (rows_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("unexpected row: pc=%h line=%h col=%h file=%h flags=%b", got.row_pc,
                 got.row_line, got.row_column, got.row_file, got[4:0]);
      end
    end else begin
      want = rows_due.pop_front();
      if (got.row_pc !== want.row_pc || got.row_line !== want.row_line ||
          got.row_column !== want.row_column || got.row_file !== want.row_file ||
          got.row_is_stmt !== want.row_is_stmt ||
          got.row_prologue_end !== want.row_prologue_end ||
          got.row_basic_block !== want.row_basic_block ||
          got.row_epilogue_begin !== want.row_epilogue_begin ||
          got.row_end_sequence !== want.row_end_sequence) begin
        errors++;
        if (errors <= 10) begin
          $display("row mismatch: expected pc=%h line=%h col=%h file=%h flags=%b",
                   want.row_pc, want.row_line, want.row_column, want.row_file, want[4:0]);
          $display("              actual   pc=%h line=%h col=%h file=%h flags=%b",
                   got.row_pc, got.row_line, got.row_column, got.row_file, got[4:0]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors            = 0;
      hdr_min_len       = 64'd1;
      hdr_max_ops       = 8'd1;
      hdr_dflt_stmt     = 1'b1;
      hdr_line_base     = 8'hFB;
      hdr_line_range    = 8'd14;
      hdr_first_special = 8'd13;
      hdr_reloc         = '0;
      hdr_low_bound     = '0;
      begin_sequence();
      rows_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_row(out_data);
      end
      if (cfg_valid && cfg_ready) begin
        apply_header(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        apply_opcode(in_data);
      end
    end
    mismatch_count <= errors;
    rows_waiting   <= rows_due.size();
  end

endmodule

@@ test/debug_line_program_interpreter_test.sv @@
// Top of the line program interpreter testbench: clock, reset, stimulus, stalls and verdict.
module debug_line_program_interpreter_test;

  localparam logic [7:0] OP_SET_ISA            = 8'd12;
  localparam logic [7:0] EXT_DEFINE_FILE       = 8'd3;
  localparam logic [7:0] EXT_SET_DISCRIMINATOR = 8'd4;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  dlpi_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready = 1'b1;
  dlpi_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [7:0]          cfg_index;
  logic [63:0]         cfg_data;
  int                  mismatch_count;
  int                  rows_waiting;

  int          burst_left;
  logic [7:0]  cur_first;
  logic [63:0] cur_low;
  int          rx_cycle;
  int          rx_hold;
  logic        rx_level;

  debug_line_program_interpreter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  debug_line_program_interpreter_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .rows_waiting   (rows_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("debug_line_program_interpreter_test: errors");
    $finish;
  end

  initial begin
    rx_cycle = 0;
    rx_hold  = 0;
    rx_level = 1'b1;
  end

  always @(negedge clk) begin
    rx_cycle++;
    case ((rx_cycle / 400) % 3)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold == 0) begin
          rx_level = !rx_level;
          rx_hold  = rx_level ? $urandom_range(1, 8) : $urandom_range(1, 20);
        end
        rx_hold--;
        out_ready <= rx_level;
      end
    endcase
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic dlpi_pkg::in_item_t mk(input logic [7:0] op, input logic [7:0] ext,
                                            input logic [63:0] operand,
                                            input logic [31:0] delta);
    dlpi_pkg::in_item_t item;
    item.op         = op;
    item.ext_op     = ext;
    item.operand    = operand;
    item.line_delta = delta;
    return item;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 300));
      1: return 64'hFFFF_FFFF_FFFF_FFFF;
      2: return 64'($urandom);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] pick_address();
    if (cur_low != 0 && $urandom_range(0, 1) == 0) begin
      return rand64() % cur_low;
    end
    if ($urandom_range(0, 1) == 0) begin
      return cur_low + 64'($urandom_range(0, 4096));
    end
    return rand64();
  endfunction

  function automatic dlpi_pkg::in_item_t body_op();
    logic [7:0] opc;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4, 5: return mk(8'($urandom_range(cur_first, 255)), 8'($urandom),
                                  rand64(), $urandom);
      6:  return mk(dlpi_pkg::OP_COPY, 8'($urandom), rand64(), $urandom);
      7:  return mk(dlpi_pkg::OP_ADVANCE_PC, 8'($urandom), pick_operand(), $urandom);
      8:  begin
        if ($urandom_range(0, 2) == 0) begin
          return mk(dlpi_pkg::OP_ADVANCE_LINE, 8'($urandom), rand64(), $urandom);
        end
        return mk(dlpi_pkg::OP_ADVANCE_LINE, 8'($urandom), rand64(),
                  32'($urandom_range(0, 200)) - 32'd100);
      end
      9:  return mk(dlpi_pkg::OP_SET_FILE, 8'($urandom), pick_operand(), $urandom);
      10: return mk(dlpi_pkg::OP_SET_COLUMN, 8'($urandom), pick_operand(), $urandom);
      11: return mk(dlpi_pkg::OP_NEGATE_STMT, 8'($urandom), rand64(), $urandom);
      12: begin
        case ($urandom_range(0, 2))
          0: opc = dlpi_pkg::OP_SET_BASIC_BLOCK;
          1: opc = dlpi_pkg::OP_SET_PROLOGUE_END;
          default: opc = dlpi_pkg::OP_SET_EPILOGUE_BEG;
        endcase
        return mk(opc, 8'($urandom), rand64(), $urandom);
      end
      13: return mk(dlpi_pkg::OP_CONST_ADD_PC, 8'($urandom), rand64(), $urandom);
      14: return mk(dlpi_pkg::OP_FIXED_ADVANCE_PC, 8'($urandom), pick_operand(), $urandom);
      default: begin
        if (cur_first > 8'd13 && $urandom_range(0, 1) == 0) begin
          return mk(8'($urandom_range(13, cur_first - 1)), 8'($urandom), rand64(), $urandom);
        end
        if ($urandom_range(0, 1) == 0) begin
          return mk(OP_SET_ISA, 8'($urandom), rand64(), $urandom);
        end
        return mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_SET_ADDRESS, pick_address(), $urandom);
      end
    endcase
  endfunction

  task automatic push_op(input dlpi_pkg::in_item_t item);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_waiting != 0) @(posedge clk);
    repeat (48) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_header(input logic [7:0] min_len, input logic [7:0] max_ops,
                              input logic dflt, input logic [7:0] base,
                              input logic [7:0] range_v, input logic [7:0] first,
                              input logic [63:0] reloc, input logic [63:0] low);
    logic [63:0] noise;
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_MIN_INST_LENGTH, {noise[63:8], min_len});
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_MAX_OPS_PER_INST, {noise[63:8], max_ops});
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_DEFAULT_STMT, {noise[63:1], dflt});
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_LINE_BASE, {noise[63:8], base});
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_LINE_RANGE, {noise[63:8], range_v});
    noise = rand64();
    cfg_write(dlpi_pkg::CFG_FIRST_SPECIAL, {noise[63:8], first});
    cfg_write(dlpi_pkg::CFG_RELOCATE_BASE, reloc);
    cfg_write(dlpi_pkg::CFG_LOW_BOUND, low);
    cur_first = first;
    cur_low   = low;
  endtask

  task automatic random_items(input int count);
    int done;
    int len;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_op(mk(8'($urandom), 8'($urandom), rand64(), $urandom));
        done++;
      end else begin
        if ($urandom_range(0, 9) < 7) begin
          push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_SET_ADDRESS, pick_address(),
                     $urandom));
          done++;
        end
        len = $urandom_range(1, 20);
        repeat (len) begin
          push_op(body_op());
          done++;
        end
        if ($urandom_range(0, 9) != 0) begin
          push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_END_SEQUENCE, rand64(), $urandom));
          done++;
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    burst_left = 0;
    cur_first  = 8'd13;
    cur_low    = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_SET_FILE, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    push_op(mk(dlpi_pkg::OP_SET_COLUMN, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, '0));
    push_op(mk(dlpi_pkg::OP_ADVANCE_LINE, 8'd0, '0, 32'h7FFF_FFFF));
    push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_ADVANCE_LINE, 8'd0, '0, 32'h8000_0000));
    push_op(mk(dlpi_pkg::OP_NEGATE_STMT, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_SET_BASIC_BLOCK, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_SET_PROLOGUE_END, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_SET_EPILOGUE_BEG, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_ADVANCE_PC, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0));
    push_op(mk(dlpi_pkg::OP_FIXED_ADVANCE_PC, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0));
    push_op(mk(dlpi_pkg::OP_CONST_ADD_PC, 8'd0, '0, '0));
    push_op(mk(8'd13, 8'd0, '0, '0));
    push_op(mk(8'd255, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    push_op(mk(OP_SET_ISA, 8'd0, rand64(), '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, EXT_SET_DISCRIMINATOR, rand64(), '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, EXT_DEFINE_FILE, rand64(), '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, 8'd0, rand64(), '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, 8'hFF, rand64(), '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_SET_ADDRESS, 64'h8000_0000_0000_0001, '0));
    push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
    push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_END_SEQUENCE, '0, '0));
    push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_header(8'd255, 8'd255, 1'b0, 8'h80, 8'd255, 8'd255,
                        64'hFFFF_FFFF_FFFF_FFFF, '0);
        1: write_header(8'd1, 8'd0, 1'b1, 8'h7F, 8'd0, 8'd1, rand64(),
                        64'h0000_0000_0001_0000);
        2: begin
          write_header(8'd4, 8'd1, 1'b1, 8'hFB, 8'd14, 8'd13, rand64(), '0);
          cfg_write(8'($urandom_range(8, 255)), rand64());
        end
        default: write_header(8'($urandom_range(1, 255)),
                              ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(0, 8)),
                              1'($urandom), 8'($urandom), 8'($urandom_range(0, 255)),
                              8'($urandom_range(1, 255)), rand64(),
                              ($urandom_range(0, 1) == 0) ? 64'd0 :
                              (rand64() >> $urandom_range(0, 63)));
      endcase
      if (cur_low != 0) begin
        push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_SET_ADDRESS, cur_low - 64'd1, '0));
        push_op(mk(cur_first, 8'd0, '0, '0));
        push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
        push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_SET_ADDRESS, cur_low, '0));
        push_op(mk(dlpi_pkg::OP_EXTENDED, dlpi_pkg::EXT_END_SEQUENCE, '0, '0));
        push_op(mk(dlpi_pkg::OP_COPY, 8'd0, '0, '0));
      end
      random_items(135);
      drain();
    end

    if (mismatch_count == 0 && rows_waiting == 0) begin
      $display("debug_line_program_interpreter_test: clean");
    end else begin
      $display("debug_line_program_interpreter_test: errors");
    end
    $finish;
  end

endmodule
